FILE: design/binary_to_decimal_text_macros.svh
// Assertion macros used by the converter design.
`ifndef BINARY_TO_DECIMAL_TEXT_MACROS_SVH
`define BINARY_TO_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define B2DT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define B2DT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/b2dt_pkg.sv
package b2dt_pkg;

  localparam int MANTISSA_BITS = 96;
  localparam int MAX_DIGITS    = 29;

  localparam int LOW_W   = 64;
  localparam int HIGH_W  = 32;
  localparam int SCALE_W = 5;
  localparam int SYM_W   = 4;

  localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(28);

  // Symbol codes
  localparam logic [SYM_W-1:0] SYM_ZERO  = SYM_W'(0);
  localparam logic [SYM_W-1:0] SYM_POINT = SYM_W'(10);

  typedef struct packed {
    logic [LOW_W-1:0]   mantissa_low;
    logic [HIGH_W-1:0]  mantissa_high;
    logic [SCALE_W-1:0] scale;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } out_word_t;

endpackage

FILE: design/binary_to_decimal_text.sv
// Binary to decimal text. Takes a 96-bit unsigned mantissa and a scale of
// 0..28 (larger values saturate to 28) and returns the decimal text as a run
// of words, most significant first: symbol 0..9 is a digit, 10 is the
// decimal point, and last marks the final word. Leading zeros are dropped; an
// empty integer part gives a leading 0, and missing fraction digits are
// padded with zeros after the point. Timing: after an item is taken, the
// converter shifts one mantissa bit per cycle through a row of 29 BCD cells,
// then walks the digit row from the top, silently skipping leading zeros one
// digit per cycle and emitting one word per cycle while the output side keeps
// up (up to 30 words). One item is in flight at a time; the next item is taken
// as soon as the final word sits in the output register.
module binary_to_decimal_text (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b2dt_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b2dt_pkg::out_word_t  out_data_o
);
  import b2dt_pkg::*;

  localparam int BcdW    = 4 * MAX_DIGITS;
  localparam int InW     = LOW_W + HIGH_W;
  localparam int ExtW    = (MANTISSA_BITS > InW) ? MANTISSA_BITS : InW;
  localparam int BitCntW = (MANTISSA_BITS > 1) ? $clog2(MANTISSA_BITS) : 1;
  localparam int PosW    = $clog2(MAX_DIGITS + 1);
  localparam int CmpW    = (PosW > SCALE_W) ? PosW : SCALE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [BitCntW-1:0]  bit_cnt_q;
  logic [PosW-1:0]     pos_q;       // digits still in the row
  logic [SCALE_W-1:0]  scale_q;
  logic                started_q;   // integer part begun
  logic                point_q;     // point already sent
  logic                out_valid_q;
  out_word_t           out_data_q;

  logic [MANTISSA_BITS-1:0] mant_q;
  logic [BcdW-1:0]          bcd_q;
  logic [BcdW-1:0]          bcd_adj;
  logic [ExtW-1:0]          mant_ext;
  logic [SCALE_W-1:0]       scale_sat;
  logic [SYM_W-1:0]         top_digit;
  logic [CmpW-1:0]          pos_cmp;
  logic [CmpW-1:0]          scale_cmp;
  logic                     in_take;
  logic                     out_free;
  logic                     out_load;
  logic                     skip_zero;
  logic                     at_point;

  assign in_take   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign mant_ext  = ExtW'({in_data_i.mantissa_high, in_data_i.mantissa_low});
  assign scale_sat = (in_data_i.scale > SCALE_LIMIT) ? SCALE_LIMIT : in_data_i.scale;
  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign pos_cmp   = CmpW'(pos_q);
  assign scale_cmp = CmpW'(scale_q);

  // Leading zero of the integer part, except the units digit when scale is 0: drop it quietly.
  assign skip_zero = !started_q && (top_digit == SYM_ZERO) &&
                     (pos_cmp > scale_cmp) && (pos_q > PosW'(1));
  // Point goes before the digit at this place (and a 0 ahead of it if the
  // integer part is empty).
  assign at_point  = (scale_q != '0) && (pos_cmp == scale_cmp) && !point_q;
  // A new word enters the output register this cycle.
  assign out_load  = (state_q == S_EMIT) && !skip_zero && out_free;

  // Double dabble: every cell at 5 or above gets +3 before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  // Digit row and mantissa shifter
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mant_q <= mant_ext[MANTISSA_BITS-1:0];
      bcd_q  <= '0;
    end else if (state_q == S_CONV) begin
      mant_q <= {mant_q[MANTISSA_BITS-2:0], 1'b0};
      bcd_q  <= {bcd_adj[BcdW-2:0], mant_q[MANTISSA_BITS-1]};
    end else if (state_q == S_EMIT && (skip_zero || (out_free && !at_point))) begin
      bcd_q  <= {bcd_q[BcdW-5:0], 4'd0};
    end
  end

  // Control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_cnt_q   <= '0;
      pos_q       <= '0;
      scale_q     <= '0;
      started_q   <= 1'b0;
      point_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q   <= S_CONV;
            bit_cnt_q <= BitCntW'(MANTISSA_BITS - 1);
            scale_q   <= scale_sat;
          end
        end
        S_CONV: begin
          bit_cnt_q <= bit_cnt_q - 1'b1;
          if (bit_cnt_q == '0) begin
            state_q   <= S_EMIT;
            pos_q     <= PosW'(MAX_DIGITS);
            started_q <= 1'b0;
            point_q   <= 1'b0;
          end
        end
        S_EMIT: begin
          if (skip_zero) begin
            pos_q <= pos_q - 1'b1;
          end else if (out_free) begin
            if (at_point) begin
              out_data_q.last <= 1'b0;
              if (!started_q) begin
                out_data_q.symbol <= SYM_ZERO;
                started_q         <= 1'b1;
              end else begin
                out_data_q.symbol <= SYM_POINT;
                point_q           <= 1'b1;
              end
            end else begin
              out_data_q.symbol <= top_digit;
              out_data_q.last   <= (pos_q == PosW'(1));
              started_q         <= 1'b1;
              pos_q             <= pos_q - 1'b1;
              if (pos_q == PosW'(1)) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "binary_to_decimal_text_macros.svh"

  // Digit walk never runs past the units digit.
  `B2DT_ASSERT_NOW(a_pos_live, state_q == S_EMIT, pos_q != '0, "emit with empty digit row")
  // Point is always followed by a digit.
  `B2DT_ASSERT_NOW(a_point_not_last, out_valid_o && out_data_o.symbol == SYM_POINT,
                   !out_data_o.last, "point flagged as last")
  // Taken item always starts a conversion.
  `B2DT_ASSERT_NEXT(a_take_conv, in_valid_i && in_ready_o, state_q == S_CONV,
                    "accepted word did not start conversion")

endmodule
